### hdl/topo_pkg.sv
// Package for the minimum-id topological sorter.
// Holds the field widths and the default sizes; no dependencies.
package topo_pkg;

    localparam int ID_W = 6;
    localparam int EDGE_W = 2 * ID_W;
    localparam int DEF_MAX_NODES = 64;
    localparam int DEF_MAX_EDGES = 256;

endpackage

### hdl/topo_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module topo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### hdl/topological_sort_min_id.sv
// Topological sorter: loads edges and emits node ids in Kahn order, smallest ready id first.
// A loading beat keeps the block busy in S_LOAD after it is taken, so no new edge is taken
// until that one is stored. After the last edge the sort passes S_INIT, then per emitted
// node S_PICK, S_EREAD and S_ECHK per stored edge, S_DEC per edge leaving it, then S_EMIT.
// Results come as single-cycle strobes on o_valid. Reset (synchronous, active low) returns the
// block to idle with an empty graph; the edge and in-degree memories need no clearing pass.
// Depends on topo_pkg and topo_ram.
module topological_sort_min_id #(
    parameter int MAX_NODES = topo_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = topo_pkg::DEF_MAX_EDGES
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [topo_pkg::ID_W-1:0] i_tail_id,
    input  logic [topo_pkg::ID_W-1:0] i_head_id,
    input  logic                    i_last_edge,
    output logic                    o_valid,
    output logic [topo_pkg::ID_W-1:0] o_node_id,
    output logic                    o_is_last,
    output logic                    o_none_ordered,
    output logic                    o_overflow
);

    localparam int NW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int DW = $clog2(MAX_EDGES + 1);
    localparam int IW = topo_pkg::ID_W;

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_INIT, S_PICK, S_EREAD, S_ECHK, S_DEC, S_EMIT
    } t_state;

    t_state r_state;
    logic [IW-1:0] r_tail, r_head, r_node;
    logic [NW-1:0] r_dnode;
    logic r_keep, r_last, r_ovf;
    logic [CW-1:0] r_count, r_eidx;
    logic [MAX_NODES-1:0] r_present, r_deg_valid, r_ready;

    logic accept, tail_ok, head_ok;
    logic [NW-1:0] pick;
    logic [CW-1:0] n_eidx;
    logic [IW-1:0] e_tail, e_head;

    logic e_we;
    logic [AW-1:0] e_raddr;
    logic [topo_pkg::EDGE_W-1:0] e_rdata;
    logic d_we;
    logic [NW-1:0] d_waddr, d_raddr;
    logic [DW-1:0] d_wdata, d_rdata, d_dec;

    assign accept = start && (r_state == S_IDLE);
    assign busy = (r_state != S_IDLE);
    assign tail_ok = ({1'b0, i_tail_id} < (IW + 1)'(MAX_NODES));
    assign head_ok = ({1'b0, i_head_id} < (IW + 1)'(MAX_NODES));
    assign e_tail = e_rdata[topo_pkg::EDGE_W-1:IW];
    assign e_head = e_rdata[IW-1:0];
    assign n_eidx = r_eidx + CW'(1);
    assign d_dec = d_rdata - DW'(1);

    always_comb begin
        pick = '0;
        for (int k = MAX_NODES - 1; k >= 0; k--) begin
            if (r_ready[k]) begin
                pick = NW'(k);
            end
        end
    end

    assign e_we = (r_state == S_LOAD) && r_keep;
    assign e_raddr = r_eidx[AW-1:0];

    always_comb begin
        d_we = 1'b0;
        d_waddr = r_head[NW-1:0];
        d_wdata = r_deg_valid[r_head[NW-1:0]] ? d_rdata + DW'(1) : DW'(1);
        d_raddr = (r_state == S_ECHK) ? e_head[NW-1:0] : i_head_id[NW-1:0];
        case (r_state)
            S_LOAD: begin
                d_we = r_keep;
            end
            S_DEC: begin
                d_waddr = r_dnode;
                d_wdata = d_dec;
                d_we = r_deg_valid[r_dnode] && (d_rdata != '0);
            end
            default: begin
                d_we = 1'b0;
            end
        endcase
    end

    topo_ram #(.WIDTH(topo_pkg::EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
        .i_clk  (i_clk),
        .i_we   (e_we),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata({r_tail, r_head}),
        .i_raddr(e_raddr),
        .o_rdata(e_rdata)
    );

    topo_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_deg_ram (
        .i_clk  (i_clk),
        .i_we   (d_we),
        .i_waddr(d_waddr),
        .i_wdata(d_wdata),
        .i_raddr(d_raddr),
        .o_rdata(d_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_eidx <= '0;
            r_present <= '0;
            r_deg_valid <= '0;
            r_ready <= '0;
            r_ovf <= 1'b0;
            r_keep <= 1'b0;
            r_last <= 1'b0;
            o_valid <= 1'b0;
            o_node_id <= '0;
            o_is_last <= 1'b0;
            o_none_ordered <= 1'b0;
            o_overflow <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_tail <= i_tail_id;
                        r_head <= i_head_id;
                        r_last <= i_last_edge;
                        r_keep <= tail_ok && head_ok && (r_count < CW'(MAX_EDGES));
                        if (tail_ok && head_ok && (r_count == CW'(MAX_EDGES))) begin
                            r_ovf <= 1'b1;
                        end
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (r_keep) begin
                        r_count <= r_count + CW'(1);
                        r_present <= r_present
                                     | (MAX_NODES'(1) << r_tail[NW-1:0])
                                     | (MAX_NODES'(1) << r_head[NW-1:0]);
                        r_deg_valid[r_head[NW-1:0]] <= 1'b1;
                    end
                    r_state <= r_last ? S_INIT : S_IDLE;
                end
                S_INIT: begin
                    r_ready <= r_present & ~r_deg_valid;
                    r_state <= S_PICK;
                end
                S_PICK: begin
                    if (r_ready == '0) begin
                        o_valid <= 1'b1;
                        o_node_id <= '0;
                        o_is_last <= 1'b1;
                        o_none_ordered <= 1'b1;
                        o_overflow <= r_ovf;
                        r_count <= '0;
                        r_present <= '0;
                        r_deg_valid <= '0;
                        r_ovf <= 1'b0;
                        r_state <= S_IDLE;
                    end else begin
                        r_node <= IW'(pick);
                        r_ready[pick] <= 1'b0;
                        r_eidx <= '0;
                        r_state <= (r_count == '0) ? S_EMIT : S_EREAD;
                    end
                end
                S_EREAD: begin
                    r_state <= S_ECHK;
                end
                S_ECHK: begin
                    if (e_tail == r_node) begin
                        r_dnode <= e_head[NW-1:0];
                        r_state <= S_DEC;
                    end else if (n_eidx == r_count) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_eidx <= n_eidx;
                        r_state <= S_EREAD;
                    end
                end
                S_DEC: begin
                    if (r_deg_valid[r_dnode] && (d_rdata != '0) && (d_dec == '0)) begin
                        r_ready[r_dnode] <= 1'b1;
                    end
                    if (n_eidx == r_count) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_eidx <= n_eidx;
                        r_state <= S_EREAD;
                    end
                end
                S_EMIT: begin
                    o_valid <= 1'b1;
                    o_node_id <= r_node;
                    o_is_last <= (r_ready == '0);
                    o_none_ordered <= 1'b0;
                    o_overflow <= r_ovf;
                    if (r_ready == '0) begin
                        r_count <= '0;
                        r_present <= '0;
                        r_deg_valid <= '0;
                        r_ovf <= 1'b0;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_PICK;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### tb/sv/topo_sort_checker.sv
// Checker for the minimum-id topological sorter: watches the edge and result channels,
// predicts the emitted order, and compares each result beat field by field.
// Depends on topo_pkg.
module topo_sort_checker #(
    parameter int MAX_NODES = topo_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = topo_pkg::DEF_MAX_EDGES
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_busy,
    input  logic [topo_pkg::ID_W-1:0] i_tail_id,
    input  logic [topo_pkg::ID_W-1:0] i_head_id,
    input  logic                      i_last_edge,
    input  logic                      i_valid,
    input  logic [topo_pkg::ID_W-1:0] i_node_id,
    input  logic                      i_is_last,
    input  logic                      i_none_ordered,
    input  logic                      i_overflow,
    output int                        o_fail_count,
    output int                        o_pending
);

    typedef struct packed {
        logic [topo_pkg::ID_W-1:0] node_id;
        logic                      is_last;
        logic                      none_ordered;
        logic                      overflow;
    } t_sort_result;

    t_sort_result              order_q[$];
    logic [topo_pkg::ID_W-1:0] arc_tail[MAX_EDGES];
    logic [topo_pkg::ID_W-1:0] arc_head[MAX_EDGES];
    int                        arc_count;
    int                        in_deg[MAX_NODES];
    logic [MAX_NODES-1:0]      present;
    logic                      dropped;
    int                        n_mismatch;

    task automatic clear_graph();
        arc_count = 0;
        present = '0;
        dropped = 1'b0;
        for (int i = 0; i < MAX_NODES; i++) begin
            in_deg[i] = 0;
        end
    endtask

    task automatic load_arc(input logic [topo_pkg::ID_W-1:0] t,
                            input logic [topo_pkg::ID_W-1:0] h);
        if (t < MAX_NODES && h < MAX_NODES) begin
            if (arc_count < MAX_EDGES) begin
                arc_tail[arc_count] = t;
                arc_head[arc_count] = h;
                arc_count++;
                present[t] = 1'b1;
                present[h] = 1'b1;
                in_deg[h]++;
            end else begin
                dropped = 1'b1;
            end
        end
    endtask

    // Kahn's scheme with the smallest ready id taken first; nodes on or behind a
    // cycle never become ready and are left out.
    task automatic predict_order();
        logic [MAX_NODES-1:0] ready;
        int                   picks[MAX_NODES];
        int                   n_out;
        int                   pick;
        t_sort_result         r;
        ready = '0;
        n_out = 0;
        for (int i = 0; i < MAX_NODES; i++) begin
            if (present[i] && in_deg[i] == 0) begin
                ready[i] = 1'b1;
            end
        end
        while (ready != '0 && n_out < 64) begin
            pick = -1;
            for (int i = MAX_NODES - 1; i >= 0; i--) begin
                if (ready[i]) begin
                    pick = i;
                end
            end
            ready[pick] = 1'b0;
            picks[n_out] = pick;
            n_out++;
            for (int e = 0; e < arc_count; e++) begin
                if (arc_tail[e] == pick && in_deg[arc_head[e]] != 0) begin
                    in_deg[arc_head[e]]--;
                    if (in_deg[arc_head[e]] == 0) begin
                        ready[arc_head[e]] = 1'b1;
                    end
                end
            end
        end
        if (n_out == 0) begin
            r.node_id = '0;
            r.is_last = 1'b1;
            r.none_ordered = 1'b1;
            r.overflow = dropped;
            order_q = {order_q, r};
        end else begin
            for (int k = 0; k < n_out; k++) begin
                r.node_id = topo_pkg::ID_W'(picks[k]);
                r.is_last = (k == n_out - 1);
                r.none_ordered = 1'b0;
                r.overflow = dropped;
                order_q = {order_q, r};
            end
        end
        clear_graph();
    endtask

    task automatic report(input string what, input t_sort_result want, input t_sort_result got);
        if (n_mismatch < 10) begin
            $display("mismatch (%s): expected %0d/%0b/%0b/%0b, got %0d/%0b/%0b/%0b",
                     what, want.node_id, want.is_last, want.none_ordered, want.overflow,
                     got.node_id, got.is_last, got.none_ordered, got.overflow);
        end
        n_mismatch++;
        o_fail_count = n_mismatch;
    endtask

    initial begin
        n_mismatch = 0;
        o_fail_count = 0;
        o_pending = 0;
        clear_graph();
    end

    always @(posedge i_clk) begin : watch
        t_sort_result want;
        t_sort_result got;
        got.node_id = i_node_id;
        got.is_last = i_is_last;
        got.none_ordered = i_none_ordered;
        got.overflow = i_overflow;
        if (!i_rst_n) begin
            clear_graph();
            order_q.delete();
        end else begin
            if (i_valid) begin
                if (order_q.size() == 0) begin
                    report("unexpected beat", '0, got);
                end else begin
                    want = order_q.pop_front();
                    if (want.node_id != got.node_id || want.is_last != got.is_last ||
                        want.none_ordered != got.none_ordered ||
                        want.overflow != got.overflow) begin
                        report("wrong field", want, got);
                    end
                end
            end
            if (i_start && !i_busy) begin
                load_arc(i_tail_id, i_head_id);
                if (i_last_edge) begin
                    predict_order();
                end
            end
        end
        o_pending = order_q.size();
    end

endmodule

### tb/sv/tb.sv
// Top of the topological sorter testbench: drives edge beats in bursts, directed graphs first
// and random graphs after, and gives the verdict. Depends on topo_pkg, the sorter and
// topo_sort_checker.
module tb;

    localparam int ID_W = topo_pkg::ID_W;
    localparam int RANDOM_ITEMS = 150;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 600;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            start = 1'b0;
    logic            busy;
    logic [ID_W-1:0] tail_id = '0;
    logic [ID_W-1:0] head_id = '0;
    logic            last_edge = 1'b0;
    logic            o_valid;
    logic [ID_W-1:0] o_node_id;
    logic            o_is_last;
    logic            o_none_ordered;
    logic            o_overflow;

    int fail_count;
    int pending;
    int burst_left = 0;
    int items_sent = 0;
    int idle_cycles = 0;

    topological_sort_min_id i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_tail_id      (tail_id),
        .i_head_id      (head_id),
        .i_last_edge    (last_edge),
        .o_valid        (o_valid),
        .o_node_id      (o_node_id),
        .o_is_last      (o_is_last),
        .o_none_ordered (o_none_ordered),
        .o_overflow     (o_overflow)
    );

    topo_sort_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_tail_id      (tail_id),
        .i_head_id      (head_id),
        .i_last_edge    (last_edge),
        .i_valid        (o_valid),
        .i_node_id      (o_node_id),
        .i_is_last      (o_is_last),
        .i_none_ordered (o_none_ordered),
        .i_overflow     (o_overflow),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[topological_sort_min_id] ERROR");
                $finish;
            end
        end
    end

    task automatic idle_gap(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start = 1'b0;
            tail_id = ID_W'($urandom);
            head_id = ID_W'($urandom);
            last_edge = 1'($urandom);
        end
    endtask

    task automatic send_arc(input int t, input int h, input int last);
        if (burst_left == 0) begin
            case ($urandom_range(0, 7))
                0, 1, 2: ;
                7: idle_gap($urandom_range(20, 60));
                default: idle_gap($urandom_range(1, 6));
            endcase
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge i_clk);
        start = 1'b1;
        tail_id = ID_W'(t);
        head_id = ID_W'(h);
        last_edge = (last != 0);
        do @(posedge i_clk); while (busy);
        items_sent++;
    endtask

    task automatic random_graph(input int n_arcs, input int hi, input bit acyclic);
        int a;
        int b;
        for (int k = 0; k < n_arcs; k++) begin
            if (acyclic) begin
                a = $urandom_range(0, hi - 1);
                b = $urandom_range(a + 1, hi);
            end else begin
                a = $urandom_range(0, hi);
                b = $urandom_range(0, hi);
            end
            send_arc(a, b, (k == n_arcs - 1) ? 1 : 0);
        end
    endtask

    initial begin : stimulus
        int base;
        int n_arcs;
        int hi;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_arc(0, 63, 1);
        send_arc(5, 5, 1);
        send_arc(3, 1, 0);
        send_arc(1, 2, 0);
        send_arc(2, 1, 0);
        send_arc(2, 4, 1);
        send_arc(10, 20, 0);
        send_arc(10, 20, 0);
        send_arc(20, 30, 1);
        send_arc(7, 3, 0);
        send_arc(9, 3, 0);
        send_arc(8, 1, 0);
        send_arc(63, 62, 1);
        send_arc(63, 63, 0);
        send_arc(0, 0, 0);
        send_arc(63, 0, 1);
        send_arc(42, 21, 0);
        send_arc(21, 42, 1);
        send_arc(1, 0, 1);

        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS) begin
            n_arcs = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            case ($urandom_range(0, 3))
                0: hi = 3;
                1: hi = 7;
                2: hi = 15;
                default: hi = 63;
            endcase
            random_graph(n_arcs, hi, $urandom_range(0, 9) < 7);
        end

        @(negedge i_clk);
        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("[topological_sort_min_id] OK");
        end else begin
            $display("[topological_sort_min_id] ERROR");
        end
        $finish;
    end

endmodule

### sim.f
hdl/topo_pkg.sv
hdl/topo_ram.sv
hdl/topological_sort_min_id.sv
tb/sv/topo_sort_checker.sv
tb/sv/tb.sv
